@@ rtl/rgbhsv_pkg.sv @@
// shared types for the rgb to hsv converter
`timescale 1ns / 1ps

package rgbhsv_pkg;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

endpackage

@@ rtl/rgb_to_hsv_converter_core.sv @@
// Pixel-rate RGB to HSV converter.
// Throughput: one pixel request per cycle while hsv_ready is high or an empty stage can close up.
// Each divider step is a pipeline stage; empty stages close up while the output stalls.
// Reset (arst_n low) clears only the stage valid bits.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core #(
	parameter int CHANNEL_BITS  = 12,
	parameter int HUE_FRAC_BITS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [CHANNEL_BITS-1:0]      red_in,
	input  logic [CHANNEL_BITS-1:0]      green_in,
	input  logic [CHANNEL_BITS-1:0]      blue_in,
	output logic                         hsv_valid,
	input  logic                         hsv_ready,
	output logic [HUE_FRAC_BITS+8:0]     hue_out,
	output logic [CHANNEL_BITS-1:0]      saturation_out,
	output logic [CHANNEL_BITS-1:0]      value_out
);
	import rgbhsv_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam int HB = HUE_FRAC_BITS + 9;
	// hue quotient never exceeds one sector, which fits in this many bits
	localparam int QB = HUE_FRAC_BITS + 6;
	localparam int ND = (CB > QB) ? CB : QB;
	localparam int NS = ND + 3;
	localparam logic [HB-1:0] SECTOR_H = HB'(60 << HUE_FRAC_BITS);
	localparam logic [HB-1:0] TURN_H   = HB'(360 << HUE_FRAC_BITS);
	localparam logic [CB+QB-1:0] SECTOR_M = (CB+QB)'(60 << HUE_FRAC_BITS);

	// stage valids and advance enables, bit 0 is the first stage
	logic [NS-1:0] stage_vld;
	logic [NS-1:0] stage_en;

	// stage 1: max, min, sector and signed difference
	logic                v_s1;
	logic [CB-1:0]       mx_s1;
	logic [CB-1:0]       mn_s1;
	logic signed [CB:0]  diff_s1;
	sector_t             sec_s1;

	// stage 2: divider operands
	logic                v_s2;
	logic [CB-1:0]       mx_s2;
	logic [CB-1:0]       delta_s2;
	logic                neg_s2;
	logic                grey_s2;
	sector_t             sec_s2;
	logic [CB-1:0]       sat_rem_s2;
	logic [CB-1:0]       sat_low_s2;
	logic [CB-1:0]       hue_rem_s2;
	logic [QB-1:0]       hue_low_s2;

	// stage 3: one register set per divider step
	logic [ND-1:0]       vld_s3;
	logic [CB-1:0]       mx_s3       [ND];
	logic [CB-1:0]       delta_s3    [ND];
	logic [ND-1:0]       neg_s3;
	logic [ND-1:0]       grey_s3;
	sector_t             sec_s3      [ND];
	logic [CB-1:0]       sat_rem_s3  [ND];
	logic [CB-1:0]       sat_low_s3  [ND];
	logic [CB-1:0]       hue_rem_s3  [ND];
	logic [QB-1:0]       hue_low_s3  [ND];

	// stage 4: output register
	logic                v_s4;
	logic [HB-1:0]       hue_s4;
	logic [CB-1:0]       sat_s4;
	logic [CB-1:0]       val_s4;

	// flow control: a stage moves when hsv_ready is high or when it or any later stage is empty
	always_comb begin
		stage_vld[0]      = v_s1;
		stage_vld[1]      = v_s2;
		stage_vld[NS-2:2] = vld_s3;
		stage_vld[NS-1]   = v_s4;
		for (int k = 0; k < NS; k++) begin
			stage_en[k] = hsv_ready |
				~&(stage_vld | ((NS'(1) << k) - NS'(1)));
		end
	end

	assign pix_ready = stage_en[0];

	// stage 1 logic
	logic          r_ge_g, r_ge_b, g_ge_b;
	logic [CB-1:0] mx_c, mn_c;
	logic [CB:0]   diff_c;
	sector_t       sec_c;

	always_comb begin
		r_ge_g = red_in >= green_in;
		r_ge_b = red_in >= blue_in;
		g_ge_b = green_in >= blue_in;
		if (r_ge_g && r_ge_b) begin
			sec_c  = SEC_RED;
			mx_c   = red_in;
			diff_c = {1'b0, green_in} - {1'b0, blue_in};
		end else if (g_ge_b) begin
			sec_c  = SEC_GREEN;
			mx_c   = green_in;
			diff_c = {1'b0, blue_in} - {1'b0, red_in};
		end else begin
			sec_c  = SEC_BLUE;
			mx_c   = blue_in;
			diff_c = {1'b0, red_in} - {1'b0, green_in};
		end
		if (!r_ge_g && !r_ge_b) begin
			mn_c = red_in;
		end else if (!g_ge_b) begin
			mn_c = green_in;
		end else begin
			mn_c = blue_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (stage_en[0]) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			mx_s1   <= mx_c;
			mn_s1   <= mn_c;
			diff_s1 <= diff_c;
			sec_s1  <= sec_c;
		end
	end

	// stage 2 logic: delta, magnitude, both dividends
	logic [CB-1:0]    delta_c;
	logic             neg_c;
	logic [CB:0]      mag_w;
	logic [2*CB-1:0]  sat_num_c;
	logic [CB+QB-1:0] hue_num_c;

	always_comb begin
		delta_c   = mx_s1 - mn_s1;
		neg_c     = diff_s1[CB];
		mag_w     = neg_c ? (~diff_s1 + 1'b1) : diff_s1;
		// delta * full scale as delta * 2^n - delta
		sat_num_c = {delta_c, {CB{1'b0}}} - {{CB{1'b0}}, delta_c};
		hue_num_c = (CB+QB)'(mag_w[CB-1:0]) * SECTOR_M;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (stage_en[1]) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			mx_s2      <= mx_s1;
			delta_s2   <= delta_c;
			neg_s2     <= neg_c;
			grey_s2    <= (delta_c == '0);
			sec_s2     <= sec_s1;
			sat_rem_s2 <= sat_num_c[2*CB-1:CB];
			sat_low_s2 <= sat_num_c[CB-1:0];
			hue_rem_s2 <= hue_num_c[CB+QB-1:QB];
			hue_low_s2 <= hue_num_c[QB-1:0];
		end
	end

	// stage 3: restoring division, one bit per step until each quotient is complete
	for (genvar k = 0; k < ND; k++) begin : g_div
		logic          src_v;
		logic [CB-1:0] src_mx, src_delta;
		logic          src_neg, src_grey;
		sector_t       src_sec;
		logic [CB-1:0] src_sat_rem, src_sat_low, src_hue_rem;
		logic [QB-1:0] src_hue_low;
		logic [CB-1:0] nxt_sat_rem, nxt_sat_low, nxt_hue_rem;
		logic [QB-1:0] nxt_hue_low;

		if (k == 0) begin : g_first
			assign src_v       = v_s2;
			assign src_mx      = mx_s2;
			assign src_delta   = delta_s2;
			assign src_neg     = neg_s2;
			assign src_grey    = grey_s2;
			assign src_sec     = sec_s2;
			assign src_sat_rem = sat_rem_s2;
			assign src_sat_low = sat_low_s2;
			assign src_hue_rem = hue_rem_s2;
			assign src_hue_low = hue_low_s2;
		end else begin : g_next
			assign src_v       = vld_s3[k-1];
			assign src_mx      = mx_s3[k-1];
			assign src_delta   = delta_s3[k-1];
			assign src_neg     = neg_s3[k-1];
			assign src_grey    = grey_s3[k-1];
			assign src_sec     = sec_s3[k-1];
			assign src_sat_rem = sat_rem_s3[k-1];
			assign src_sat_low = sat_low_s3[k-1];
			assign src_hue_rem = hue_rem_s3[k-1];
			assign src_hue_low = hue_low_s3[k-1];
		end

		// saturation step, divisor is the maximum
		if (k < CB) begin : g_sat
			logic [CB:0] trial;
			logic        take;
			always_comb begin
				trial       = {src_sat_rem, src_sat_low[CB-1]};
				take        = trial >= {1'b0, src_mx};
				nxt_sat_rem = take ? CB'(trial - {1'b0, src_mx}) : trial[CB-1:0];
				nxt_sat_low = {src_sat_low[CB-2:0], take};
			end
		end else begin : g_sat_hold
			assign nxt_sat_rem = src_sat_rem;
			assign nxt_sat_low = src_sat_low;
		end

		// hue step, divisor is delta
		if (k < QB) begin : g_hue
			logic [CB:0] trial;
			logic        take;
			always_comb begin
				trial       = {src_hue_rem, src_hue_low[QB-1]};
				take        = trial >= {1'b0, src_delta};
				nxt_hue_rem = take ? CB'(trial - {1'b0, src_delta}) : trial[CB-1:0];
				nxt_hue_low = {src_hue_low[QB-2:0], take};
			end
		end else begin : g_hue_hold
			assign nxt_hue_rem = src_hue_rem;
			assign nxt_hue_low = src_hue_low;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k] <= 1'b0;
			end else if (stage_en[k+2]) begin
				vld_s3[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en[k+2]) begin
				mx_s3[k]      <= src_mx;
				delta_s3[k]   <= src_delta;
				neg_s3[k]     <= src_neg;
				grey_s3[k]    <= src_grey;
				sec_s3[k]     <= src_sec;
				sat_rem_s3[k] <= nxt_sat_rem;
				sat_low_s3[k] <= nxt_sat_low;
				hue_rem_s3[k] <= nxt_hue_rem;
				hue_low_s3[k] <= nxt_hue_low;
			end
		end
	end

	// stage 4 logic: sector offset, sign and wrap
	logic [HB-1:0] q_c;
	logic [HB-1:0] off_c;
	logic [HB-1:0] hue_c;

	always_comb begin
		q_c = HB'(hue_low_s3[ND-1]);
		case (sec_s3[ND-1])
			SEC_RED:   off_c = '0;
			SEC_GREEN: off_c = SECTOR_H << 1;
			SEC_BLUE:  off_c = SECTOR_H << 2;
			default:   off_c = '0;
		endcase
		if (grey_s3[ND-1]) begin
			hue_c = '0;
		end else if (!neg_s3[ND-1]) begin
			hue_c = off_c + q_c;
		end else if (sec_s3[ND-1] == SEC_RED && q_c != '0) begin
			// negative hue in the red sector wraps by one turn
			hue_c = TURN_H - q_c;
		end else begin
			hue_c = off_c - q_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (stage_en[NS-1]) begin
			v_s4 <= vld_s3[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[NS-1]) begin
			hue_s4 <= hue_c;
			sat_s4 <= grey_s3[ND-1] ? '0 : sat_low_s3[ND-1];
			val_s4 <= mx_s3[ND-1];
		end
	end

	// outputs
	assign hsv_valid      = v_s4;
	assign hue_out        = hue_s4;
	assign saturation_out = sat_s4;
	assign value_out      = val_s4;

endmodule
